@@ sv/awq_pkg.sv @@
// ----------------------------------------------------------------------------
// awq_pkg
// Shared widths, constants and types of the aligned wake-up block.
// ----------------------------------------------------------------------------
package awq_pkg;

    localparam int TIME_W      = 17;
    localparam int MIN_W       = 11;
    localparam int OUT_W       = 18;
    localparam int DIFF_W      = OUT_W + 1;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // one dividend bit per pipeline stage
    localparam int DIV_STEPS = TIME_W;

    localparam logic [TIME_W-1:0] DAY_SECONDS    = TIME_W'(86400);
    localparam logic [TIME_W-1:0] LAST_SECOND    = TIME_W'(86399);
    localparam logic [TIME_W-1:0] HOUR_SECONDS   = TIME_W'(3600);
    localparam logic [TIME_W-1:0] MIN_GAP        = TIME_W'(60);
    localparam logic [MIN_W-1:0]  LAST_MINUTE    = MIN_W'(1439);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATE      = 2'd0,
        CFG_QUIET_EN    = 2'd1,
        CFG_QUIET_START = 2'd2,
        CFG_QUIET_END   = 2'd3
    } awq_cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0] rotate_interval_seconds;
        logic              quiet_enabled;
        logic [MIN_W-1:0]  quiet_start_minute;
        logic [MIN_W-1:0]  quiet_end_minute;
    } awq_cfg_t;

    // classified request, all values already clamped into range
    typedef struct packed {
        logic [TIME_W-1:0] cur;
        logic [TIME_W-1:0] r;
        logic [TIME_W-1:0] qs;
        logic [TIME_W-1:0] qe;
        logic              crosses;
        logic              qen;
    } awq_item_t;

endpackage

@@ sv/awq_front.sv @@
// ----------------------------------------------------------------------------
// awq_front
// Configuration registers, input stage and request classification.
// ----------------------------------------------------------------------------
module awq_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [awq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [awq_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [awq_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              push,
    output awq_pkg::awq_item_t                push_item,
    input  logic                              q_full
);
    import awq_pkg::*;

    awq_cfg_t          cfg_reg;
    logic              fv_reg;
    awq_item_t         item_reg;
    awq_item_t         item_next;
    logic [TIME_W-1:0] raw_now;
    logic [MIN_W-1:0]  st_min;
    logic [MIN_W-1:0]  en_min;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotate_interval_seconds <= HOUR_SECONDS;
            cfg_reg.quiet_enabled           <= 1'b0;
            cfg_reg.quiet_start_minute      <= '0;
            cfg_reg.quiet_end_minute        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (awq_cfg_idx_t'(cfg_index))
                CFG_ROTATE:      cfg_reg.rotate_interval_seconds <= cfg_data[TIME_W-1:0];
                CFG_QUIET_EN:    cfg_reg.quiet_enabled           <= cfg_data[0];
                CFG_QUIET_START: cfg_reg.quiet_start_minute      <= cfg_data[MIN_W-1:0];
                CFG_QUIET_END:   cfg_reg.quiet_end_minute        <= cfg_data[MIN_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // clamp everything into range and work out the window shape
    always_comb
    begin
        raw_now = s_tdata[TIME_W-1:0];
        st_min  = (cfg_reg.quiet_start_minute > LAST_MINUTE) ?
                  LAST_MINUTE : cfg_reg.quiet_start_minute;
        en_min  = (cfg_reg.quiet_end_minute > LAST_MINUTE) ?
                  LAST_MINUTE : cfg_reg.quiet_end_minute;

        item_next.cur = (raw_now > LAST_SECOND) ? LAST_SECOND : raw_now;
        if (cfg_reg.rotate_interval_seconds == '0)
            item_next.r = TIME_W'(1);
        else if (cfg_reg.rotate_interval_seconds > DAY_SECONDS)
            item_next.r = DAY_SECONDS;
        else
            item_next.r = cfg_reg.rotate_interval_seconds;
        // minutes times 60 as 64x - 4x
        item_next.qs      = TIME_W'({st_min, 6'b0}) - TIME_W'({st_min, 2'b0});
        item_next.qe      = TIME_W'({en_min, 6'b0}) - TIME_W'({en_min, 2'b0});
        item_next.crosses = st_min > en_min;
        item_next.qen     = cfg_reg.quiet_enabled;
    end

    assign s_tready  = !fv_reg || !q_full;
    assign push      = fv_reg && !q_full;
    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (s_tready)
            fv_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= item_next;
    end

endmodule

@@ sv/awq_queue.sv @@
// ----------------------------------------------------------------------------
// awq_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module awq_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  awq_pkg::awq_item_t push_item,
    output logic               full,
    input  logic               pop,
    output awq_pkg::awq_item_t pop_item,
    output logic               not_empty
);
    import awq_pkg::*;

    awq_item_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_item;
    end

endmodule

@@ sv/awq_rem_pipe.sv @@
// ----------------------------------------------------------------------------
// awq_rem_pipe
// Pipelined restoring remainder, one dividend bit per stage, two lanes:
// current time mod interval and window end mod interval.
// ----------------------------------------------------------------------------
module awq_rem_pipe (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  awq_pkg::awq_item_t         in_item,
    output logic                       out_valid,
    output awq_pkg::awq_item_t         out_item,
    output logic [awq_pkg::TIME_W-1:0] out_rem_cur,
    output logic [awq_pkg::TIME_W-1:0] out_rem_qe
);
    import awq_pkg::*;

    logic [DIV_STEPS-1:0] vld_reg;
    awq_item_t            item_reg [DIV_STEPS];
    logic [TIME_W-1:0]    rc_reg   [DIV_STEPS];
    logic [TIME_W-1:0]    rq_reg   [DIV_STEPS];

    logic [DIV_STEPS-1:0] src_vld;
    awq_item_t            src_item [DIV_STEPS];
    logic [TIME_W-1:0]    src_rc   [DIV_STEPS];
    logic [TIME_W-1:0]    src_rq   [DIV_STEPS];
    logic [TIME_W-1:0]    rc_next  [DIV_STEPS];
    logic [TIME_W-1:0]    rq_next  [DIV_STEPS];

    function automatic logic [TIME_W-1:0] rem_step(
        input logic [TIME_W-1:0] rem,
        input logic              dbit,
        input logic [TIME_W-1:0] dvs
    );
        logic [TIME_W:0] t;
        t = {rem, dbit};
        if (t >= {1'b0, dvs})
            return TIME_W'(t - {1'b0, dvs});
        else
            return t[TIME_W-1:0];
    endfunction

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign src_vld[k]  = in_valid;
            assign src_item[k] = in_item;
            assign src_rc[k]   = '0;
            assign src_rq[k]   = '0;
        end
        else
        begin : g_next
            assign src_vld[k]  = vld_reg[k-1];
            assign src_item[k] = item_reg[k-1];
            assign src_rc[k]   = rc_reg[k-1];
            assign src_rq[k]   = rq_reg[k-1];
        end
        // stage k brings in dividend bit DIV_STEPS-1-k, msb first
        assign rc_next[k] = rem_step(src_rc[k], src_item[k].cur[DIV_STEPS-1-k], src_item[k].r);
        assign rq_next[k] = rem_step(src_rq[k], src_item[k].qe[DIV_STEPS-1-k], src_item[k].r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= src_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                item_reg[k] <= src_item[k];
                rc_reg[k]   <= rc_next[k];
                rq_reg[k]   <= rq_next[k];
            end
        end
    end

    assign out_valid   = vld_reg[DIV_STEPS-1];
    assign out_item    = item_reg[DIV_STEPS-1];
    assign out_rem_cur = rc_reg[DIV_STEPS-1];
    assign out_rem_qe  = rq_reg[DIV_STEPS-1];

endmodule

@@ sv/awq_back.sv @@
// ----------------------------------------------------------------------------
// awq_back
// Remainder pipeline, wake-up and quiet window evaluation, output register.
// ----------------------------------------------------------------------------
module awq_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_not_empty,
    input  awq_pkg::awq_item_t                 q_item,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [awq_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import awq_pkg::*;

    logic              adv;
    logic              p_vld;
    awq_item_t         p_item;
    logic [TIME_W-1:0] p_rc;
    logic [TIME_W-1:0] p_rq;

    // stage a
    logic              a_vld_reg;
    awq_item_t         a_item_reg;
    logic [OUT_W-1:0]  a_until_reg;
    logic [OUT_W-1:0]  a_aend_reg;
    logic [TIME_W-1:0] until0;
    logic [OUT_W-1:0]  a_until_next;
    logic [OUT_W-1:0]  a_aend_next;

    // stage b
    logic              b_vld_reg;
    awq_item_t         b_item_reg;
    logic [OUT_W-1:0]  b_until_reg;
    logic [TIME_W-1:0] b_wake_reg;
    logic [DIFF_W-1:0] b_diff_reg;
    logic [OUT_W-1:0]  wake_raw;
    logic [TIME_W-1:0] b_wake_next;
    logic [DIFF_W-1:0] b_diff_next;

    // output
    logic              out_vld_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              in_window;
    logic [DIFF_W-1:0] diff_day;
    logic [OUT_W-1:0]  res_next;

    assign adv = !out_vld_reg || m_tready;
    assign pop = adv && q_not_empty;

    awq_rem_pipe u_rem_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (q_not_empty),
        .in_item     (q_item),
        .out_valid   (p_vld),
        .out_item    (p_item),
        .out_rem_cur (p_rc),
        .out_rem_qe  (p_rq)
    );

    always_comb
    begin
        until0 = p_item.r - p_rc;
        // too close: skip one more interval
        a_until_next = (until0 < MIN_GAP) ?
                       OUT_W'(until0) + OUT_W'(p_item.r) : OUT_W'(until0);
        // window end rounded up to the interval
        a_aend_next = (p_rq == '0) ? OUT_W'(p_item.qe) :
                      OUT_W'(p_item.qe) + OUT_W'(p_item.r) - OUT_W'(p_rq);
    end

    always_comb
    begin
        wake_raw    = OUT_W'(a_item_reg.cur) + a_until_reg;
        b_wake_next = (wake_raw >= OUT_W'(DAY_SECONDS)) ?
                      TIME_W'(wake_raw - OUT_W'(DAY_SECONDS)) : wake_raw[TIME_W-1:0];
        b_diff_next = DIFF_W'(a_aend_reg) - DIFF_W'(a_item_reg.cur);
    end

    always_comb
    begin
        if (b_item_reg.crosses)
            in_window = (b_wake_reg >= b_item_reg.qs) || (b_wake_reg < b_item_reg.qe);
        else
            in_window = (b_wake_reg >= b_item_reg.qs) && (b_wake_reg < b_item_reg.qe);
        diff_day = b_diff_reg + DIFF_W'(DAY_SECONDS);

        if (!b_item_reg.qen || !in_window)
            res_next = b_until_reg;
        else if (b_item_reg.crosses)
            res_next = (b_item_reg.cur < b_item_reg.qe) ?
                       b_diff_reg[OUT_W-1:0] : diff_day[OUT_W-1:0];
        else
            // same-day window whose aligned end already passed: next day
            res_next = b_diff_reg[DIFF_W-1] ? diff_day[OUT_W-1:0] : b_diff_reg[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg   <= p_vld;
            b_vld_reg   <= a_vld_reg;
            out_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg   <= p_item;
            a_until_reg  <= a_until_next;
            a_aend_reg   <= a_aend_next;
            b_item_reg   <= a_item_reg;
            b_until_reg  <= a_until_reg;
            b_wake_reg   <= b_wake_next;
            b_diff_reg   <= b_diff_next;
            out_data_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

@@ sv/aligned_wakeup_with_quiet_window_top.sv @@
// ----------------------------------------------------------------------------
// aligned_wakeup_with_quiet_window_top
// Seconds until the next aligned wake-up, deferred past a quiet window.
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one request per beat, s_tdata[16:0] is the current second of
//   the day. m_* stream: one result per request, in order, m_tdata[17:0] is
//   the number of seconds until the chosen wake-up.
//   cfg_* channel: cfg_index selects the register (0 interval, 1 quiet
//   enable, 2 quiet start minute, 3 quiet end minute), cfg_data carries the
//   value; cfg_ready is always high. write only while no request is in flight.
// timing
//   a request accepted on s_* passes the input stage, the queue, the 17-stage
//   remainder pipeline, stages a and b and the output register before m_tvalid.
//   one request per cycle is sustained while m_tready stays high.
// reset
//   rst_n clears all valids and loads interval 3600 s, quiet window off,
//   start and end minute 0.
// stall
//   while m_tready is low with m_tvalid high the back pipeline holds; the 4-entry
//   queue and the input stage keep taking requests until they fill, then s_tready drops.
// ----------------------------------------------------------------------------
module aligned_wakeup_with_quiet_window_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [awq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [awq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [awq_pkg::IN_TDATA_W-1:0]     s_tdata,  // [16:0] now_second_of_day
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [awq_pkg::OUT_TDATA_W-1:0]    m_tdata   // [17:0] seconds_to_wake
);
    import awq_pkg::*;

    logic      push;
    awq_item_t push_item;
    logic      q_full;
    logic      pop;
    awq_item_t pop_item;
    logic      q_not_empty;

    awq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    awq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (q_not_empty)
    );

    awq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

@@ sv/awq_checker.sv @@
// ----------------------------------------------------------------------------
// awq_checker
// Port-level checks of the aligned wake-up block, bound to the top level.
// ----------------------------------------------------------------------------
module awq_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [awq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [awq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [awq_pkg::IN_TDATA_W-1:0]     s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [awq_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import awq_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{cfg_index, cfg_data, s_tvalid, s_tready, s_tdata};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // never more than two days ahead, pad bits zero
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:OUT_W] == '0) &&
                     (m_tdata[OUT_W-1:0] <= OUT_W'(172800)))
        else $error("result out of range");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind aligned_wakeup_with_quiet_window_top awq_checker u_awq_checker (.*);

@@ tb/aligned_wakeup_with_quiet_window_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aligned_wakeup_with_quiet_window_top_tb
// Self-checking bench for the aligned wake-up scheduler.
// Requests carry the current second of the day. Each one is predicted from
// the bench's own copy of the registers and checked in order against
// m_tdata. Directed tests cover the interval, time and minute limits, the
// quiet window cases and the disabled schedule. The random phases follow with
// random settings, the first 25 with random backpressure on both streams.
// ----------------------------------------------------------------------------
module aligned_wakeup_with_quiet_window_top_tb;

    import awq_pkg::*;

    localparam int DAY         = int'(DAY_SECONDS);
    localparam int GAP_MIN     = int'(MIN_GAP);
    localparam int DRAIN_WAIT  = 25;
    localparam int STALL_LIMIT = 5000;
    localparam int TIME_MAX    = (1 << TIME_W) - 1;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;   // [16:0] now_second_of_day
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;   // [17:0] seconds_to_wake

    // register copy, reset values
    logic [TIME_W-1:0] interval_reg = HOUR_SECONDS;
    logic              quiet_en_reg = 1'b0;
    logic [MIN_W-1:0]  quiet_start_reg = '0;
    logic [MIN_W-1:0]  quiet_end_reg = '0;

    logic [OUT_W-1:0]  wake_delays_due[$];
    int                mismatch_count = 0;
    int                stall_cycles = 0;
    bit                bursts_on = 1'b1;

    aligned_wakeup_with_quiet_window_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [OUT_W-1:0] wake_delay(input logic [TIME_W-1:0] now_raw);
        int  r;
        int  cur;
        int  to_wake;
        int  wake;
        int  qs;
        int  qe;
        int  aligned_end;
        int  res;
        bit  crosses;
        bit  in_window;
        r   = (interval_reg > DAY_SECONDS) ? DAY : int'(interval_reg);
        cur = (now_raw > LAST_SECOND) ? int'(LAST_SECOND) : int'(now_raw);
        if (r == 0)
            r = 1;
        to_wake = r - (cur % r);
        if (to_wake < GAP_MIN)
            to_wake += r;
        if (!quiet_en_reg)
            return to_wake[OUT_W-1:0];
        wake = cur + to_wake;
        if (wake >= DAY)
            wake -= DAY;
        qs = ((quiet_start_reg > LAST_MINUTE) ? int'(LAST_MINUTE) : int'(quiet_start_reg)) * 60;
        qe = ((quiet_end_reg > LAST_MINUTE) ? int'(LAST_MINUTE) : int'(quiet_end_reg)) * 60;
        crosses = qs > qe;
        if (crosses)
            in_window = (wake >= qs) || (wake < qe);
        else
            in_window = (wake >= qs) && (wake < qe);
        if (!in_window)
            return to_wake[OUT_W-1:0];
        aligned_end = ((qe + r - 1) / r) * r;
        if (crosses)
            res = (cur < qe) ? aligned_end - cur : (DAY - cur) + aligned_end;
        else
        begin
            res = aligned_end - cur;
            // wake wrapped past midnight into an early same-day window
            if (res < 0)
                res += DAY;
        end
        return res[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // result check first, then queue the prediction for a newly accepted request
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (wake_delays_due.size() == 0)
                report_mismatch($sformatf("result %0d with no request pending",
                                          m_tdata[OUT_W-1:0]));
            else if (m_tdata[OUT_W-1:0] !== wake_delays_due[0])
            begin
                report_mismatch($sformatf("seconds_to_wake expected %0d got %0d",
                                          wake_delays_due[0], m_tdata[OUT_W-1:0]));
                void'(wake_delays_due.pop_front());
            end
            else
                void'(wake_delays_due.pop_front());
        end
        if (rst_n && s_tvalid && s_tready)
            wake_delays_due.push_back(wake_delay(s_tdata[TIME_W-1:0]));
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // output backpressure in random bursts
    initial
    begin : sink_driver
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (bursts_on && $urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 14);
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n - 1) @(negedge clk);
        end
    end

    task automatic write_reg(input awq_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ROTATE:      interval_reg    = value[TIME_W-1:0];
            CFG_QUIET_EN:    quiet_en_reg    = value[0];
            CFG_QUIET_START: quiet_start_reg = value[MIN_W-1:0];
            CFG_QUIET_END:   quiet_end_reg   = value[MIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // only called with no request in flight
    task automatic set_config(input logic [CFG_DATA_W-1:0] interval, input logic qen,
                              input logic [MIN_W-1:0] qs, input logic [MIN_W-1:0] qe);
        write_reg(CFG_ROTATE, interval);
        write_reg(CFG_QUIET_EN, CFG_DATA_W'(qen));
        write_reg(CFG_QUIET_START, CFG_DATA_W'(qs));
        write_reg(CFG_QUIET_END, CFG_DATA_W'(qe));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_time(input logic [TIME_W-1:0] now_sec);
        int gap;
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - TIME_W){1'b0}}, now_sec};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (wake_delays_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [TIME_W-1:0] random_time(input logic [MIN_W-1:0] qs,
                                                      input logic [MIN_W-1:0] qe);
        int t;
        case ($urandom_range(0, 7))
            0: t = int'($urandom_range(DAY, TIME_MAX));
            1: t = int'(qs) * 60 - int'($urandom_range(0, 4000));
            2: t = int'(qe) * 60 - int'($urandom_range(0, 4000));
            3: t = int'($urandom_range(DAY - 400, DAY - 1));
            default: t = int'($urandom_range(0, DAY - 1));
        endcase
        if (t < 0)
            t += DAY;
        return t[TIME_W-1:0];
    endfunction

    task automatic test_reset_values();
        send_time(0);
        send_time(3540);
        send_time(3541);
        send_time(3599);
        send_time(86399);
        send_time(TIME_MAX);    // above the last second of the day
        wait_idle();
    endtask

    task automatic test_interval_limits();
        set_config(0, 1'b0, 0, 0);          // zero acts as one second
        send_time(12345);
        wait_idle();
        set_config(1, 1'b0, 0, 0);
        send_time(0);
        wait_idle();
        set_config(TIME_MAX, 1'b0, 0, 0);   // saturates to one day
        send_time(100);
        wait_idle();
        set_config(86400, 1'b0, 0, 0);
        send_time(86350);
        wait_idle();
    endtask

    task automatic test_quiet_window();
        set_config(3600, 1'b1, 60, 120);
        send_time(3000);
        send_time(100);
        wait_idle();
        // wake wraps to just after midnight, window earlier in the day
        set_config(3600, 1'b1, 0, 120);
        send_time(85000);
        wait_idle();
        set_config(3600, 1'b1, 600, 600);   // empty window
        send_time(35000);
        wait_idle();
        set_config(3600, 1'b1, 1320, 360);  // crosses midnight
        send_time(77000);
        send_time(3000);
        wait_idle();
        set_config(3600, 1'b1, 2047, 2047); // both minutes saturate, empty
        send_time(86000);
        wait_idle();
        set_config(900, 1'b1, 2047, 30);
        send_time(86300);
        wait_idle();
        set_config(3600, 1'b0, 1320, 360);  // schedule off
        send_time(77000);
        wait_idle();
    endtask

    task automatic random_phase(input int n_items);
        logic [CFG_DATA_W-1:0] iv;
        logic [MIN_W-1:0]      qs;
        logic [MIN_W-1:0]      qe;
        case ($urandom_range(0, 9))
            0: iv = 0;
            1: iv = 1;
            2: iv = 86400;
            3: iv = CFG_DATA_W'($urandom_range(86401, TIME_MAX));
            4: iv = 60;
            5: iv = CFG_DATA_W'($urandom_range(2, 120));
            6: iv = 3600;
            default: iv = CFG_DATA_W'($urandom_range(1, 86400));
        endcase
        qs = MIN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) :
                                                  $urandom_range(0, 1439));
        qe = MIN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) :
                                                  $urandom_range(0, 1439));
        if ($urandom_range(0, 9) == 0)
            qe = qs;
        set_config(iv, $urandom_range(0, 4) != 0, qs, qe);
        repeat (n_items)
            send_time(random_time(qs, qe));
        wait_idle();
    endtask

    task automatic test_random();
        repeat (25)
            random_phase(50);
        bursts_on = 1'b0;
        repeat (2)
            random_phase(50);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROTATE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_interval_limits();
        test_quiet_window();
        test_random();

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
